// ===== design/lrut_pkg.sv =====
package lrut_pkg;

	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned KEY_BITS_DEF   = 32;
	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned CFG_BITS       = 5;
	localparam int unsigned TTL_BITS       = 31;
	localparam int unsigned TIME_BITS      = 32;
	localparam int unsigned EXP_BITS       = TIME_BITS + 1;
	localparam logic [CFG_BITS-1:0] LIMIT_RST = CFG_BITS'(16);

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_MISS = 1'b1;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2,
		OP_CLR = 2'd3
	} lrut_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} lrut_state_t;

endpackage

// ===== design/lrut_slot_mem.sv =====
module lrut_slot_mem
	import lrut_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [VALUE_BITS-1:0] rd_value,
	output logic [EXP_BITS-1:0]   rd_expiry,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [VALUE_BITS-1:0] wr_value,
	input  logic [EXP_BITS-1:0]   wr_expiry
);

	// Value and expiry live side by side in one word per slot.
	logic [VALUE_BITS+EXP_BITS-1:0] mem [CAPACITY];
	logic [VALUE_BITS+EXP_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_value, wr_expiry};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_value  = rd_q[VALUE_BITS+EXP_BITS-1:EXP_BITS];
	assign rd_expiry = rd_q[EXP_BITS-1:0];

endmodule

// ===== design/lru_cache_with_ttl.sv =====
// Key-value cache with least-recently-used replacement and per-entry expiry.
// A request is taken when start is high and busy is low. On acceptance the key
// is compared against all stored keys at once and the slot memory (value and
// expiry) is read; then, in the execute state, the result is formed and the
// recency ranks, keys and memory are written back. Exactly one result follows
// each request, in the first cycle in which busy is low again, marked by done
// for a single cycle; it cannot be held off, and a new request may be started
// in that same cycle, but none is taken while busy. The entry
// limit register is written over the cfg port when not busy; 0 acts as 1
// and values above the capacity act as the capacity.
module lru_cache_with_ttl
	import lrut_pkg::*;
#(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
	localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            req_type,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] write_value,
	input  logic [TTL_BITS-1:0]   ttl,
	input  logic [TIME_BITS-1:0]  now_time,
	output logic                  done,
	output logic                  status,
	output logic [VALUE_BITS-1:0] read_value,
	output logic [CNT_W-1:0]      entry_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_BITS-1:0]   cfg_data
);

	localparam int unsigned LIM_W = ((CNT_W > CFG_BITS) ? CNT_W : CFG_BITS) + 1;
	localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAPACITY);

	lrut_state_t state_q, state_d;

	logic [CAPACITY-1:0] valid_q, valid_d;
	logic [IDX_W-1:0]    rank_q [CAPACITY];
	logic [IDX_W-1:0]    rank_d [CAPACITY];
	logic [KEY_BITS-1:0] key_q  [CAPACITY];
	logic [CNT_W-1:0]    live_q, live_d;
	logic [CFG_BITS-1:0] max_q;

	// Request fields held for the execute cycle.
	lrut_op_t              op_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic [TTL_BITS-1:0]   ttl_s1;
	logic [TIME_BITS-1:0]  now_s1;
	logic                  hit_s1;
	logic [IDX_W-1:0]      slot_s1;

	logic                  accept;
	logic                  lk_hit;
	logic [IDX_W-1:0]      lk_slot;

	logic [VALUE_BITS-1:0] mem_value;
	logic [EXP_BITS-1:0]   mem_expiry;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [EXP_BITS-1:0]   new_expiry;

	logic                  res_fire;
	logic                  res_status;
	logic [VALUE_BITS-1:0] res_value;

	logic [LIM_W-1:0]      limit;
	logic [CAPACITY-1:0]   victim_oh;
	logic [CAPACITY-1:0]   valid_ev;
	logic [IDX_W-1:0]      free_idx;
	logic [IDX_W-1:0]      r_sel;
	logic                  expired;

	logic                  done_q;
	logic                  status_q;
	logic [VALUE_BITS-1:0] value_q;

	assign busy      = (state_q == ST_EXEC);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;

	// Parallel key compare; the lowest matching slot wins.
	always_comb begin
		lk_hit  = 1'b0;
		lk_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key) begin
				lk_hit  = 1'b1;
				lk_slot = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				res_fire = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= lrut_op_t'(req_type);
			key_s1  <= key;
			val_s1  <= write_value;
			ttl_s1  <= ttl;
			now_s1  <= now_time;
			hit_s1  <= lk_hit;
			slot_s1 <= lk_slot;
		end
	end

	lrut_slot_mem #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (lk_slot),
		.rd_value  (mem_value),
		.rd_expiry (mem_expiry),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_value  (val_s1),
		.wr_expiry (new_expiry)
	);

	always_comb begin
		if (max_q == '0) begin
			limit = LIM_W'(1);
		end else if (LIM_W'(max_q) > CAP_L) begin
			limit = CAP_L;
		end else begin
			limit = LIM_W'(max_q);
		end
	end

	assign new_expiry = (ttl_s1 == '0) ? '0 : (EXP_BITS'(now_s1) + EXP_BITS'(ttl_s1));
	assign expired    = (mem_expiry != '0) && (EXP_BITS'(now_s1) >= mem_expiry);
	assign r_sel      = rank_q[slot_s1];

	// The victim holds the oldest rank; with ranks dense that is live_count - 1.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			victim_oh[i] = valid_q[i] && (LIM_W'(live_q) >= limit)
				&& ((CNT_W'(rank_q[i]) + CNT_W'(1)) == live_q);
		end
		valid_ev = valid_q & ~victim_oh;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_ev[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		valid_d    = valid_q;
		rank_d     = rank_q;
		live_d     = live_q;
		wr_en      = 1'b0;
		wr_addr    = slot_s1;
		res_status = STATUS_OK;
		res_value  = '0;
		if (state_q == ST_EXEC) begin
			case (op_s1)
				OP_SET: begin
					wr_en = 1'b1;
					if (hit_s1) begin
						for (int i = 0; i < CAPACITY; i++) begin
							if (valid_q[i] && rank_q[i] < r_sel) begin
								rank_d[i] = rank_q[i] + IDX_W'(1);
							end
						end
						rank_d[slot_s1] = '0;
					end else begin
						wr_addr = free_idx;
						for (int i = 0; i < CAPACITY; i++) begin
							if (valid_ev[i]) begin
								rank_d[i] = rank_q[i] + IDX_W'(1);
							end else begin
								rank_d[i] = '0;
							end
						end
						rank_d[free_idx] = '0;
						valid_d = valid_ev;
						valid_d[free_idx] = 1'b1;
						live_d = (|victim_oh) ? live_q : live_q + CNT_W'(1);
					end
				end
				OP_GET, OP_DEL: begin
					if (!hit_s1) begin
						res_status = STATUS_MISS;
					end else if (op_s1 == OP_GET && !expired) begin
						res_value = mem_value;
						for (int i = 0; i < CAPACITY; i++) begin
							if (valid_q[i] && rank_q[i] < r_sel) begin
								rank_d[i] = rank_q[i] + IDX_W'(1);
							end
						end
						rank_d[slot_s1] = '0;
					end else begin
						if (op_s1 == OP_GET) begin
							res_status = STATUS_MISS;
						end
						for (int i = 0; i < CAPACITY; i++) begin
							if (valid_q[i] && rank_q[i] > r_sel) begin
								rank_d[i] = rank_q[i] - IDX_W'(1);
							end
						end
						rank_d[slot_s1]  = '0;
						valid_d[slot_s1] = 1'b0;
						live_d = live_q - CNT_W'(1);
					end
				end
				OP_CLR: begin
					valid_d = '0;
					for (int i = 0; i < CAPACITY; i++) begin
						rank_d[i] = '0;
					end
					live_d = '0;
				end
				default: begin
					valid_d = valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			max_q   <= LIMIT_RST;
			done_q  <= 1'b0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			live_q  <= live_d;
			rank_q  <= rank_d;
			done_q  <= res_fire;
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !hit_s1) begin
			key_q[free_idx] <= key_s1;
		end
		if (res_fire) begin
			status_q <= res_status;
			value_q  <= res_value;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = value_q;
	assign entry_count = live_q;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result strobe without an execute cycle");

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(live_q))
		else $error("live count disagrees with valid slots");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_IDLE)
		else $error("execute cycle did not return to idle");

endmodule
